/* rtl/core/jsl_pkg.sv */
// Package with the types, codes and byte tables of the JSON stream lexer.
`timescale 1ns / 1ps
package jsl_pkg;

    localparam int STACK_LEVELS = 32;
    localparam int LVL_W = $clog2(STACK_LEVELS);

    localparam logic [2:0] T_ROOT = 3'd0;
    localparam logic [2:0] T_OBJ  = 3'd1;
    localparam logic [2:0] T_LIST = 3'd2;
    localparam logic [2:0] T_STR  = 3'd3;
    localparam logic [2:0] T_KEY  = 3'd4;
    localparam logic [2:0] T_BARE = 3'd5;

    localparam logic [1:0] EX_NONE  = 2'd0;
    localparam logic [1:0] EX_QUOTE = 2'd1;
    localparam logic [1:0] EX_COLON = 2'd2;
    localparam logic [1:0] EX_COMMA = 2'd3;

    localparam logic [1:0] TK_NONE  = 2'd0;
    localparam logic [1:0] TK_COLON = 2'd1;
    localparam logic [1:0] TK_COMMA = 2'd2;

    localparam logic [1:0] K_PUSH = 2'd0;
    localparam logic [1:0] K_POP  = 2'd1;
    localparam logic [1:0] K_UESC = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    localparam logic [3:0] E_CTRL     = 4'd0;
    localparam logic [3:0] E_COLON    = 4'd1;
    localparam logic [3:0] E_STRAY    = 4'd2;
    localparam logic [3:0] E_STROUT   = 4'd3;
    localparam logic [3:0] E_ESCOUT   = 4'd4;
    localparam logic [3:0] E_INSERT   = 4'd5;
    localparam logic [3:0] E_KEYEXP   = 4'd6;
    localparam logic [3:0] E_BRACKET  = 4'd7;
    localparam logic [3:0] E_NULL     = 4'd8;
    localparam logic [3:0] E_BAREEXP  = 4'd9;
    localparam logic [3:0] E_TOODEEP  = 4'd10;

    localparam logic [2:0] NO_BARE = 3'd7;

    localparam logic [0:0] REG_EVENT_ENABLE = 1'd0;
    localparam logic [0:0] REG_MAX_LEVEL    = 1'd1;

    // One event as it leaves the lexer.
    typedef struct packed {
        logic [1:0]  event_kind;
        logic [2:0]  value_type;
        logic [4:0]  nest_level;
        logic [31:0] begin_pos;
        logic [31:0] current_pos;
        logic [31:0] element_count;
        logic [2:0]  bareword_kind;
        logic [3:0]  error_code;
        logic        last_of_run;
    } t_event;

    // Up to two events caused by one byte.
    typedef struct packed {
        logic [1:0] cnt;
        t_event     ev0;
        t_event     ev1;
    } t_bundle;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
    } t_in;

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h20;
    endfunction

    function automatic logic ends_bare(input logic [7:0] c);
        return is_ws(c) || c == 8'h22 || c == 8'h2c || c == 8'h3a || c == 8'h5b ||
               c == 8'h5c || c == 8'h5d || c == 8'h7b || c == 8'h7d;
    endfunction

    function automatic logic [2:0] bare_kind(input logic [7:0] c);
        if (c == 8'h2d) return 3'd0;
        if (c >= 8'h30 && c <= 8'h39) return 3'd1;
        if (c == 8'h74) return 3'd2;
        if (c == 8'h66) return 3'd3;
        if (c == 8'h6e) return 3'd4;
        return NO_BARE;
    endfunction

endpackage

/* rtl/core/jsl_stream_if.sv */
// Valid/ready channel interface carrying a generic payload.
`timescale 1ns / 1ps
interface jsl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/jsl_front.sv */
// Front part: per-byte parse against the stack, producing event bundles.
`timescale 1ns / 1ps
module jsl_front import jsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte,
    output logic        o_valid,
    input  logic        i_space,
    output t_bundle     o_bundle
);

    // Stack, kept in flip-flops: each byte writes only the top and the level
    // above it; after a pop it may also read the levels below.
    logic [2:0]  r_type  [STACK_LEVELS];
    logic [31:0] r_count [STACK_LEVELS];
    logic [31:0] r_begin [STACK_LEVELS];
    logic [2:0]  r_bare  [STACK_LEVELS];
    logic [LVL_W-1:0] r_depth, n_depth;
    logic [1:0]  r_exp, n_exp;
    logic [1:0]  r_prev, n_prev;
    logic        r_ins, n_ins;
    logic        r_esc, n_esc;
    logic [31:0] r_pos;
    logic        r_halt, n_halt;
    logic [5:0]  r_en;
    logic [5:0]  r_maxlvl;

    logic        fire;
    assign o_ready = i_space;
    assign fire    = i_valid && i_space;

    // Combinational next-state working copies of the top two levels.
    logic [LVL_W-1:0] lo;
    logic [LVL_W-1:0] hi;
    logic [2:0]  w_type [2];
    logic [31:0] w_cnt  [2];
    logic [31:0] w_beg  [2];
    logic [2:0]  w_bare [2];
    logic        w_hi_we;
    logic        w_lo_we;
    t_bundle     bun;

    always_comb begin
        logic [7:0] c;
        logic [2:0] t;
        logic       stringy;
        logic       done;
        logic [2:0] k;
        logic [1:0] want;
        c = i_byte;
        lo = r_depth;
        hi = (r_depth == LVL_W'(STACK_LEVELS - 1)) ? r_depth : r_depth + 1'b1;
        w_type[0] = r_type[lo];  w_cnt[0] = r_count[lo];
        w_beg[0]  = r_begin[lo]; w_bare[0] = r_bare[lo];
        w_type[1] = r_type[hi];  w_cnt[1] = r_count[hi];
        w_beg[1]  = r_begin[hi]; w_bare[1] = r_bare[hi];
        w_hi_we = 1'b0;
        w_lo_we = 1'b0;
        n_depth = r_depth; n_exp = r_exp; n_prev = r_prev; n_ins = r_ins;
        n_esc = r_esc; n_halt = r_halt;
        bun = '0;
        t = w_type[0];
        stringy = (t == T_STR) || (t == T_KEY);
        done = 1'b0;
        k = bare_kind(c);
        want = EX_NONE;

        if (!r_halt) begin
            if (r_esc) begin
                n_esc = 1'b0;
                if (c == 8'h75) add_ev(K_UESC, 3'd5, 4'd0);
                done = 1'b1;
            end else if (stringy) begin
                if ((c >= 8'h23 && c != 8'h5c) || c == 8'h20) done = 1'b1;
                else if (c < 8'h20) begin fail(E_CTRL); done = 1'b1; end
            end else if (t == T_BARE) begin
                if ((c >= 8'h30 && c < 8'h40) || !ends_bare(c)) done = 1'b1;
                else if (is_ws(c)) begin pop_bare(); n_exp = EX_NONE; done = 1'b1; end
            end else if (is_ws(c)) begin
                done = 1'b1;
            end

            if (!done) begin
                if (c == 8'h22) begin
                    n_ins = 1'b0;
                    if (stringy) begin
                        pop_bare();
                    end else if (t == T_OBJ) begin
                        w_cnt[0] = w_cnt[0] + 1; w_lo_we = 1'b1;
                        if (!w_cnt[0][0]) begin
                            if (r_prev != TK_COLON) fail(E_COLON);
                            else begin
                                n_exp = EX_COMMA;
                                do_push(T_STR, 3'd0, 3'd2);
                            end
                        end else begin
                            if (r_exp != EX_QUOTE) fail(E_STRAY);
                            else begin
                                n_prev = TK_NONE; n_exp = EX_COLON;
                                do_push(T_KEY, 3'd0, 3'd3);
                            end
                        end
                    end else if (t == T_LIST) begin
                        w_cnt[0] = w_cnt[0] + 1; w_lo_we = 1'b1;
                        do_push(T_STR, 3'd0, 3'd2);
                        if (!n_halt) n_exp = EX_COMMA;
                    end else if (t == T_BARE) fail(E_STRAY);
                    else fail(E_STROUT);
                end else if (c == 8'h5c) begin
                    if (!stringy) fail(E_ESCOUT);
                    else n_esc = 1'b1;
                end else if (stringy) begin
                    // plain string byte
                end else if (c == 8'h3a || c == 8'h2c) begin
                    want = (c == 8'h3a) ? EX_COLON : EX_COMMA;
                    if (c == 8'h2c) begin
                        if (t == T_BARE) pop_bare();
                        n_exp = EX_COMMA;
                    end
                    if (n_exp != want) fail(E_STRAY);
                    else begin
                        if (cur_type() == T_OBJ && c == 8'h2c) n_exp = EX_QUOTE;
                        n_prev = (c == 8'h3a) ? TK_COLON : TK_COMMA;
                        n_ins = 1'b1;
                    end
                end else if (c == 8'h5b || c == 8'h7b) begin
                    if (!r_ins) fail(E_INSERT);
                    else if (!w_cnt[0][0] && t == T_OBJ) fail(E_KEYEXP);
                    else begin
                        w_cnt[0] = w_cnt[0] + 1; w_lo_we = 1'b1;
                        do_push((c == 8'h7b) ? T_OBJ : T_LIST, 3'd0,
                                (c == 8'h7b) ? 3'd0 : 3'd1);
                        if (!n_halt) begin
                            n_ins = 1'b1;
                            if (c == 8'h7b) n_exp = EX_QUOTE;
                            n_prev = TK_NONE;
                        end
                    end
                end else if (c == 8'h5d || c == 8'h7d) begin
                    if (t == T_BARE) begin pop_bare(); n_exp = EX_NONE; end
                    n_ins = 1'b0;
                    if (cur_type() != ((c == 8'h7d) ? T_OBJ : T_LIST)) fail(E_BRACKET);
                    else begin
                        n_exp = EX_COMMA;
                        pop_bare();
                    end
                end else if (t != T_BARE) begin
                    if (k == NO_BARE) begin
                        if (c == 8'h00) fail(E_NULL);
                        else if (c < 8'h20) fail(E_CTRL);
                        else fail(E_BAREEXP);
                    end else if (!w_cnt[0][0] && t == T_OBJ) fail(E_KEYEXP);
                    else begin
                        w_cnt[0] = w_cnt[0] + 1; w_lo_we = 1'b1;
                        do_push(T_BARE, k, 3'd4);
                    end
                end
            end
        end
        if (bun.cnt == 2'd1) bun.ev0.last_of_run = 1'b1;
        if (bun.cnt == 2'd2) bun.ev1.last_of_run = 1'b1;
    end

    // Helpers operating on the working copies above.
    function automatic logic [2:0] cur_type();
        return (n_depth == r_depth) ? w_type[0] : r_type[n_depth];
    endfunction

    function automatic void add_ev(input logic [1:0] kind, input logic [2:0] bit_n,
                                   input logic [3:0] err);
        t_event e;
        logic [LVL_W-1:0] idx;
        logic [2:0] ty;
        idx = n_depth;
        e = '0;
        if (kind != K_ERR &&
            !(r_en[bit_n] && {{(32-6){1'b0}}, r_maxlvl} > 32'(idx))) return;
        if (bun.cnt == 2'd2) return;
        if (idx == hi && hi != lo) begin
            ty = w_type[1]; e.begin_pos = w_beg[1]; e.element_count = w_cnt[1];
            e.bareword_kind = (ty == T_BARE) ? w_bare[1] : 3'd0;
        end else if (idx == lo) begin
            ty = w_type[0]; e.begin_pos = w_beg[0]; e.element_count = w_cnt[0];
            e.bareword_kind = (ty == T_BARE) ? w_bare[0] : 3'd0;
        end else begin
            ty = r_type[idx]; e.begin_pos = r_begin[idx]; e.element_count = r_count[idx];
            e.bareword_kind = (ty == T_BARE) ? r_bare[idx] : 3'd0;
        end
        e.event_kind = kind;
        e.value_type = ty;
        e.nest_level = 5'(idx);
        e.current_pos = r_pos;
        e.error_code = (kind == K_ERR) ? err : 4'd0;
        if (bun.cnt == 2'd0) bun.ev0 = e; else bun.ev1 = e;
        bun.cnt = bun.cnt + 1'b1;
    endfunction

    function automatic void fail(input logic [3:0] code);
        add_ev(K_ERR, 3'd0, code);
        n_halt = 1'b1;
    endfunction

    // Pop the top entry, event bit taken from its type.
    function automatic void pop_bare();
        logic [2:0] ty;
        ty = cur_type();
        add_ev(K_POP, (ty >= 3'd1) ? ty - 3'd1 : 3'd0, 4'd0);
        if (n_depth != '0) n_depth = n_depth - 1'b1;
    endfunction

    function automatic void do_push(input logic [2:0] ty, input logic [2:0] bk,
                                    input logic [2:0] bit_n);
        if (r_depth >= LVL_W'(STACK_LEVELS - 1)) begin
            fail(E_TOODEEP);
            return;
        end
        n_depth = hi;
        w_type[1] = ty; w_cnt[1] = '0; w_beg[1] = r_pos; w_bare[1] = bk;
        w_hi_we = 1'b1;
        add_ev(K_PUSH, bit_n, 4'd0);
    endfunction

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0; r_exp <= EX_NONE; r_prev <= TK_NONE; r_ins <= 1'b1;
            r_esc <= 1'b0; r_pos <= '0; r_halt <= 1'b0;
            r_en <= 6'd63; r_maxlvl <= 6'd32;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_EVENT_ENABLE) r_en <= i_cfg_data;
                else r_maxlvl <= i_cfg_data;
            end
            if (fire) begin
                r_depth <= n_depth; r_exp <= n_exp; r_prev <= n_prev; r_ins <= n_ins;
                r_esc <= n_esc; r_halt <= n_halt;
                if (!n_halt) r_pos <= r_pos + 32'd1;
            end
        end
    end

    // Stack entries: reset to zero, then written only at top levels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STACK_LEVELS; i++) begin
                r_type[i] <= '0; r_count[i] <= '0; r_begin[i] <= '0; r_bare[i] <= '0;
            end
        end else if (fire) begin
            if (w_lo_we) r_count[lo] <= w_cnt[0];
            if (w_hi_we) begin
                r_type[hi] <= w_type[1]; r_count[hi] <= w_cnt[1];
                r_begin[hi] <= w_beg[1]; r_bare[hi] <= w_bare[1];
            end
        end
    end

    assign o_valid  = fire && (bun.cnt != 2'd0);
    assign o_bundle = bun;

endmodule

/* rtl/core/jsl_back.sv */
// Back part: queue of event bundles and serialization to one event per request.
`timescale 1ns / 1ps
module jsl_back import jsl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_bundle i_bundle,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_event  o_event
);

    localparam int QD = 4;
    t_bundle     r_q [QD];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;
    logic        r_half;

    logic pop_ev, pop_b;
    t_bundle head;

    assign head    = r_q[r_rp];
    assign o_space = (r_cnt < 3'(QD - 1)) || (r_cnt == 3'(QD - 1) && pop_b);
    assign o_valid = (r_cnt != 3'd0);
    assign o_event = r_half ? head.ev1 : head.ev0;
    assign pop_ev  = o_valid && i_ready;
    assign pop_b   = pop_ev && (r_half || head.cnt == 2'd1);

    // Queue pointers and the second-event flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_half <= 1'b0;
        end else begin
            if (i_valid) r_wp <= r_wp + 1'b1;
            if (pop_b) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 3'(i_valid) - 3'(pop_b);
            if (pop_ev) r_half <= !pop_b;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_valid) r_q[r_wp] <= i_bundle;
    end

endmodule

/* rtl/core/json_stream_lexer.sv */
// Top level of the JSON stream lexer.
// Each byte's events are built combinationally and registered in the output queue on accept.
// Throughput: one byte per cycle while that queue has space; a byte with two events holds
// the output for both, absorbed by a three-bundle queue between parse and output.
// Reset: synchronous, active low; clears the stack, positions and queue pointers, sets config defaults.
`timescale 1ns / 1ps
module json_stream_lexer import jsl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    jsl_stream_if.sink   in_ch,
    jsl_stream_if.source out_ch
);

    logic    f_valid, space;
    t_bundle bun;
    t_in     din;

    assign din = in_ch.data;

    jsl_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(in_ch.valid), .o_ready(in_ch.ready), .i_byte(din.data_byte),
        .o_valid(f_valid), .i_space(space), .o_bundle(bun)
    );

    jsl_back u_back (
        .i_clk, .i_rst_n, .i_valid(f_valid), .i_bundle(bun), .o_space(space),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready), .o_event(out_ch.data)
    );

endmodule

/* rtl/core/jsl_checker.sv */
// Port-level checker for the JSON stream lexer and its bind.
`timescale 1ns / 1ps
module jsl_checker import jsl_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input t_event out_data
);
    // An error event always closes its byte's run.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.event_kind == K_ERR |-> out_data.last_of_run)
        else $error("error event not last");
    // Error code only on error events.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.event_kind != K_ERR |-> out_data.error_code == 4'd0)
        else $error("stray error code");
    // Stalled output holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed under stall");
    // Nothing appears right after reset.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output after reset");
    // The queue is empty after reset, so a request is taken at once.
    a_rdy: assert property (@(posedge i_clk) !i_rst_n |=> in_ready)
        else $error("input not ready after reset");
endmodule

bind json_stream_lexer jsl_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

/* test/tb_json_stream_lexer.sv */
// Self-checking testbench for the JSON stream lexer with a scoreboard that predicts every event.
`timescale 1ns / 1ps
module tb_json_stream_lexer;
    import jsl_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 150;

    // Scoreboard: tracks the parse state and the queue of events still owed.
    class event_scoreboard;
        logic [2:0]  lvl_type[STACK_LEVELS];
        logic [31:0] lvl_count[STACK_LEVELS];
        logic [31:0] lvl_begin[STACK_LEVELS];
        logic [2:0]  lvl_bare[STACK_LEVELS];
        int unsigned top;
        logic [1:0]  want_tok;
        logic [1:0]  last_tok;
        bit          may_insert;
        bit          esc_pending;
        bit          halted;
        logic [31:0] pos;
        logic [5:0]  kind_mask;
        logic [5:0]  level_cap;
        t_event      owed[$];
        t_event      byte_events[$];
        int          errors;
        int          matched;

        function new();
            for (int i = 0; i < STACK_LEVELS; i++) begin
                lvl_type[i] = T_ROOT;
                lvl_count[i] = '0;
                lvl_begin[i] = '0;
                lvl_bare[i] = '0;
            end
            top = 0;
            want_tok = EX_NONE;
            last_tok = TK_NONE;
            may_insert = 1;
            esc_pending = 0;
            halted = 0;
            pos = '0;
            kind_mask = 6'd63;
            level_cap = 6'd32;
            errors = 0;
            matched = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [5:0] val);
            if (idx == REG_EVENT_ENABLE) kind_mask = val;
            else level_cap = val;
        endfunction

        function bit blank(logic [7:0] c);
            return c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h20;
        endfunction

        function bit word_stop(logic [7:0] c);
            case (c)
                8'h22, 8'h2c, 8'h3a, 8'h5b, 8'h5c, 8'h5d, 8'h7b, 8'h7d: return 1;
                default: return blank(c);
            endcase
        endfunction

        function logic [2:0] word_class(logic [7:0] c);
            if (c == 8'h2d) return 3'd0;
            if (c >= 8'h30 && c <= 8'h39) return 3'd1;
            if (c == 8'h74) return 3'd2;
            if (c == 8'h66) return 3'd3;
            if (c == 8'h6e) return 3'd4;
            return NO_BARE;
        endfunction

        function void record(logic [1:0] kind, int unsigned idx, logic [3:0] code);
            t_event e;
            if (byte_events.size() >= 2 || idx >= STACK_LEVELS) return;
            e.event_kind = kind;
            e.value_type = lvl_type[idx];
            e.nest_level = idx[4:0];
            e.begin_pos = lvl_begin[idx];
            e.current_pos = pos;
            e.element_count = lvl_count[idx];
            e.bareword_kind = (lvl_type[idx] == T_BARE) ? lvl_bare[idx] : 3'd0;
            e.error_code = (kind == K_ERR) ? code : 4'd0;
            e.last_of_run = 1'b0;
            byte_events.push_back(e);
        endfunction

        // Push, pop and escape events pass the type mask and the level cap.
        function void announce(logic [1:0] kind, int bitnum, int unsigned idx);
            if (kind_mask[bitnum] && level_cap > idx) record(kind, idx, 4'd0);
        endfunction

        function void abort(logic [3:0] code);
            record(K_ERR, top, code);
            halted = 1;
        endfunction

        function bit open_level();
            if (top >= STACK_LEVELS - 1) begin
                abort(E_TOODEEP);
                return 0;
            end
            top++;
            lvl_begin[top] = pos;
            lvl_count[top] = '0;
            lvl_bare[top] = '0;
            return 1;
        endfunction

        function void close_top();
            int unsigned d;
            d = top;
            announce(K_POP, (lvl_type[d] >= 1) ? lvl_type[d] - 1 : 0, d);
            if (d > 0) top = d - 1;
        endfunction

        function void quote_seen(logic [2:0] t);
            int unsigned d;
            d = top;
            may_insert = 0;
            if (t == T_STR || t == T_KEY) begin
                close_top();
            end else if (t == T_OBJ) begin
                lvl_count[d]++;
                if (((lvl_count[d] - 1) & 1) != 0) begin
                    if (last_tok != TK_COLON) begin
                        abort(E_COLON);
                        return;
                    end
                    want_tok = EX_COMMA;
                    if (!open_level()) return;
                    lvl_type[top] = T_STR;
                    announce(K_PUSH, 2, top);
                end else begin
                    if (want_tok != EX_QUOTE) begin
                        abort(E_STRAY);
                        return;
                    end
                    last_tok = TK_NONE;
                    want_tok = EX_COLON;
                    if (!open_level()) return;
                    lvl_type[top] = T_KEY;
                    announce(K_PUSH, 3, top);
                end
            end else if (t == T_LIST) begin
                lvl_count[d]++;
                if (!open_level()) return;
                lvl_type[top] = T_STR;
                want_tok = EX_COMMA;
                announce(K_PUSH, 2, top);
            end else if (t == T_BARE) begin
                abort(E_STRAY);
            end else begin
                abort(E_STROUT);
            end
        endfunction

        function void parse_byte(logic [7:0] c);
            int unsigned d;
            logic [2:0] t;
            logic [2:0] k;
            logic [2:0] closer;
            logic [1:0] want;
            bit textual;
            d = top;
            t = lvl_type[d];
            textual = (t == T_STR || t == T_KEY);
            if (esc_pending) begin
                esc_pending = 0;
                if (c == 8'h75) announce(K_UESC, 5, d);
                return;
            end
            if (textual) begin
                if ((c >= 8'h23 && c != 8'h5c) || c == 8'h20) return;
                if (c < 8'h20) begin
                    abort(E_CTRL);
                    return;
                end
            end else if (t == T_BARE) begin
                if ((c >= 8'h30 && c < 8'h40) || !word_stop(c)) return;
                if (blank(c)) begin
                    close_top();
                    want_tok = EX_NONE;
                    return;
                end
            end else if (blank(c)) begin
                return;
            end
            if (c == 8'h22) begin
                quote_seen(t);
                return;
            end
            if (c == 8'h5c) begin
                if (!textual) abort(E_ESCOUT);
                else esc_pending = 1;
                return;
            end
            if (textual) return;

            if (c == 8'h3a || c == 8'h2c) begin
                want = (c == 8'h3a) ? EX_COLON : EX_COMMA;
                if (c == 8'h2c) begin
                    if (lvl_type[top] == T_BARE) close_top();
                    want_tok = EX_COMMA;
                end
                if (want_tok != want) begin
                    abort(E_STRAY);
                    return;
                end
                if (lvl_type[top] == T_OBJ && c == 8'h2c) want_tok = EX_QUOTE;
                last_tok = (c == 8'h3a) ? TK_COLON : TK_COMMA;
                may_insert = 1;
            end else if (c == 8'h5b || c == 8'h7b) begin
                if (!may_insert) begin
                    abort(E_INSERT);
                    return;
                end
                if (!lvl_count[d][0] && t == T_OBJ) begin
                    abort(E_KEYEXP);
                    return;
                end
                lvl_count[d]++;
                if (!open_level()) return;
                lvl_type[top] = (c == 8'h7b) ? T_OBJ : T_LIST;
                may_insert = 1;
                if (c == 8'h7b) want_tok = EX_QUOTE;
                announce(K_PUSH, (c == 8'h7b) ? 0 : 1, top);
                last_tok = TK_NONE;
            end else if (c == 8'h5d || c == 8'h7d) begin
                closer = (c == 8'h7d) ? T_OBJ : T_LIST;
                if (lvl_type[top] == T_BARE) begin
                    close_top();
                    want_tok = EX_NONE;
                end
                may_insert = 0;
                d = top;
                if (lvl_type[d] != closer) begin
                    abort(E_BRACKET);
                    return;
                end
                want_tok = EX_COMMA;
                announce(K_POP, closer - 1, d);
                if (d > 0) top = d - 1;
            end else if (t != T_BARE) begin
                k = word_class(c);
                if (k == NO_BARE) begin
                    if (c == 8'h00) abort(E_NULL);
                    else if (c < 8'h20) abort(E_CTRL);
                    else abort(E_BAREEXP);
                    return;
                end
                if (!lvl_count[d][0] && t == T_OBJ) begin
                    abort(E_KEYEXP);
                    return;
                end
                lvl_count[d]++;
                if (!open_level()) return;
                lvl_type[top] = T_BARE;
                lvl_bare[top] = k;
                announce(K_PUSH, 4, top);
            end
        endfunction

        // Note an accepted request and queue the events it must cause.
        function void note_request(t_in req);
            if (halted) return;
            byte_events.delete();
            parse_byte(req.data_byte);
            if (!halted) pos++;
            if (byte_events.size() > 0) byte_events[byte_events.size() - 1].last_of_run = 1'b1;
            foreach (byte_events[i]) owed.push_back(byte_events[i]);
        endfunction

        function void diff(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        // Compare one delivered event with the oldest one owed.
        function void check_event(t_event got);
            t_event want;
            if (owed.size() == 0) begin
                $error("event_kind mismatch: expected none, actual %0d", got.event_kind);
                errors++;
                return;
            end
            want = owed.pop_front();
            matched++;
            diff("event_kind", want.event_kind, got.event_kind);
            diff("value_type", want.value_type, got.value_type);
            diff("nest_level", want.nest_level, got.nest_level);
            diff("begin_pos", want.begin_pos, got.begin_pos);
            diff("current_pos", want.current_pos, got.current_pos);
            diff("element_count", want.element_count, got.element_count);
            diff("bareword_kind", want.bareword_kind, got.bareword_kind);
            diff("error_code", want.error_code, got.error_code);
            diff("last_of_run", want.last_of_run, got.last_of_run);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [5:0] i_cfg_data;

    jsl_stream_if #(.T(t_in))    in_ch ();
    jsl_stream_if #(.T(t_event)) out_ch ();

    json_stream_lexer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    event_scoreboard sb;
    logic [7:0] text_q[$];
    bit  steady;
    bit  hold_req;
    int  bytes_sent;
    int  idle_cycles;

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver side: random stalls, plus one long hold-off when requested.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            out_ch.ready = steady ? 1'b1 : ($urandom_range(99) >= 17);
        end
    end

    // Event checker, and a watchdog on accepted requests and delivered events.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) sb.check_event(out_ch.data);
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        t_in req;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 17) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req.data_byte = b;
        req.chunk_end = 1'($urandom_range(1));
        in_ch.data = req;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(req);
        bytes_sent++;
    endtask

    task automatic send_text();
        while (text_q.size() > 0) send_byte(text_q.pop_front());
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // Wait until every owed event has arrived, then let the pipeline settle.
    task automatic drain();
        while (sb.owed.size() > 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [5:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    function automatic void add_ws();
        logic [7:0] pick[4] = '{8'h09, 8'h0a, 8'h0d, 8'h20};
        repeat ($urandom_range(2)) text_q.push_back(pick[$urandom_range(3)]);
    endfunction

    function automatic void add_string();
        logic [7:0] c;
        text_q.push_back(8'h22);
        repeat ($urandom_range(4)) begin
            if ($urandom_range(5) == 0) begin
                text_q.push_back(8'h5c);
                text_q.push_back(($urandom_range(1) == 0) ? 8'h75 : 8'($urandom_range(255)));
            end else begin
                do c = 8'($urandom_range(255, 32)); while (c == 8'h22 || c == 8'h5c);
                text_q.push_back(c);
            end
        end
        text_q.push_back(8'h22);
    endfunction

    // A bareword; the caller always follows it with a byte that ends it.
    function automatic void add_word();
        logic [7:0] lead[5] = '{8'h2d, 8'h31, 8'h74, 8'h66, 8'h6e};
        logic [7:0] c;
        text_q.push_back(lead[$urandom_range(4)]);
        repeat ($urandom_range(3)) begin
            do c = 8'($urandom_range(255)); while (sb.word_stop(c));
            text_q.push_back(c);
        end
    endfunction

    // Well-formed value with random content; containers only below the depth cap.
    function automatic void add_value(int lvl, bit allow_str);
        int pick;
        pick = $urandom_range(allow_str ? 3 : 2);
        if (lvl >= 5 && pick < 2) pick = 2;
        if (pick == 0) begin
            text_q.push_back(8'h7b);
            add_ws();
            for (int i = $urandom_range(3); i > 0; i--) begin
                add_string();
                add_ws();
                text_q.push_back(8'h3a);
                add_ws();
                add_value(lvl + 1, 1);
                add_ws();
                if (i > 1) begin
                    text_q.push_back(8'h2c);
                    add_ws();
                end
            end
            text_q.push_back(8'h7d);
        end else if (pick == 1) begin
            text_q.push_back(8'h5b);
            add_ws();
            for (int i = $urandom_range(3); i > 0; i--) begin
                add_value(lvl + 1, 1);
                add_ws();
                if (i > 1) text_q.push_back(8'h2c);
            end
            text_q.push_back(8'h5d);
        end else if (pick == 2) begin
            add_word();
        end else begin
            add_string();
        end
    endfunction

    task automatic random_phase(int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n) begin
            if ($urandom_range(19) == 0) begin
                // Nesting right up to the deepest legal level.
                repeat (STACK_LEVELS - 2) text_q.push_back(8'h5b);
                text_q.push_back(8'h37);
                repeat (STACK_LEVELS - 2) text_q.push_back(8'h5d);
            end else begin
                add_value(1, 0);
            end
            text_q.push_back(8'h2c);
            add_ws();
            send_text();
        end
    endtask

    initial begin
        sb = new();
        steady = 0;
        hold_req = 0;
        bytes_sent = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_EVENT_ENABLE;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every entry type, escapes, 0xff in text and a word, a list inside a word.
        add_str("{\"k\":\"a\\u\\\"\",\"n\":[-5,true,");
        text_q.push_back(8'h22);
        text_q.push_back(8'hff);
        text_q.push_back(8'h22);
        add_str(",f");
        text_q.push_back(8'hff);
        add_str(" ,n[0]]},");
        send_text();
        drain();

        // Back-to-back phase, then a long receiver hold-off while bytes keep coming.
        steady = 1;
        random_phase(PHASE_BYTES);
        hold_req = 1;
        random_phase(PHASE_BYTES / 2);
        steady = 0;
        drain();

        write_reg(REG_EVENT_ENABLE, 6'd0);
        write_reg(REG_MAX_LEVEL, 6'd0);
        random_phase(PHASE_BYTES / 2);
        drain();
        write_reg(REG_EVENT_ENABLE, 6'($urandom_range(63)));
        write_reg(REG_MAX_LEVEL, 6'($urandom_range(32)));
        random_phase(PHASE_BYTES);
        drain();
        write_reg(REG_EVENT_ENABLE, 6'd63);
        write_reg(REG_MAX_LEVEL, 6'd1);
        random_phase(PHASE_BYTES / 2);
        drain();
        write_reg(REG_MAX_LEVEL, 6'd32);
        random_phase(PHASE_BYTES);
        drain();

        // Closing phase: a malformed tail drives the lexer into its halt.
        if ($urandom_range(1) == 0) begin
            repeat (STACK_LEVELS) text_q.push_back(8'h7b);
        end
        while (!sb.halted && bytes_sent < 5000) begin
            text_q.push_back(8'($urandom_range(255)));
            send_text();
        end
        send_text();
        repeat (20) text_q.push_back(8'($urandom_range(255)));
        send_text();
        drain();

        $display("Run covered %0d bytes and %0d checked events, ending in halt=%0b.",
                 bytes_sent, sb.matched, sb.halted);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
